// ===== hw/rtl/pxhp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxhp_pkg
// Types, codes and character constants for the PROXY v1 header parser.
// ----------------------------------------------------------------------------
package pxhp_pkg;

	localparam int HOST_LEN_LIMIT_DEF = 63;
	localparam int CFG_IDX_W          = 2;
	localparam int CFG_DATA_W         = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEADER_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOST_LEN   = 2'd1;

	localparam logic [7:0] MAX_HEADER_LEN_RST = 8'd107;
	localparam logic [5:0] MAX_HOST_LEN_RST   = 6'd46;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_6     = 8'h36;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] LINE_SAT = 8'd255;

	localparam logic [16:0] PORT_MAX = 17'd65535;
	localparam logic [16:0] PORT_SAT = 17'd65536;

	typedef enum logic [2:0] {
		PH_DET0,
		PH_DET1,
		PH_PARSE,
		PH_ACC,
		PH_NOHDR,
		PH_ERR
	} phase_t;

	typedef enum logic [2:0] {
		ST_PENDING  = 3'd0,
		ST_ACCEPTED = 3'd1,
		ST_NOHDR    = 3'd2,
		ST_ERROR    = 3'd3,
		ST_DATA     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FAM_UNKNOWN = 2'd0,
		FAM_TCP4    = 2'd1,
		FAM_TCP6    = 2'd2
	} family_t;

	typedef enum logic [2:0] {
		TK_LEAD   = 3'd0,
		TK_FAMILY = 3'd1,
		TK_SRC    = 3'd2,
		TK_DST    = 3'd3,
		TK_SPORT  = 3'd4,
		TK_TAIL   = 3'd5
	} token_t;

	typedef enum logic [1:0] {
		PR_PEND,
		PR_ACC,
		PR_HOST,
		PR_ERR
	} parse_res_t;

	// one processed word: one result, or the no-header pair
	typedef struct packed {
		logic [2:0]  status;
		logic        data_valid;
		logic [7:0]  data_byte;
		logic        host_valid;
		logic [7:0]  host_byte;
		logic [1:0]  family;
		logic [15:0] source_port;
		logic        pair;
		logic [7:0]  data_byte2;
	} res_t;

	function automatic logic [7:0] lead_char(input logic [5:0] pos);
		logic [7:0] c;
		case (pos)
			6'd0:    c = 8'h50;
			6'd1:    c = 8'h52;
			6'd2:    c = 8'h4F;
			6'd3:    c = 8'h58;
			6'd4:    c = 8'h59;
			6'd5:    c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] fam_char(input logic [5:0] pos);
		logic [7:0] c;
		case (pos)
			6'd0:    c = CH_T;
			6'd1:    c = CH_C;
			6'd2:    c = CH_P;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/proxy_v1_header_parser_unit.sv =====
`timescale 1ns / 1ps
// Accepted words are registered in the input stage, results in the result queue.
// Throughput: one word per cycle while the result queue has room; the second word
// of a stream without header yields two results, which the port shows in turn.
// The rate is set by the single parse stage and the two-entry result queue.
// Reset (arst_n low, asynchronous): parser waits for the first word, registers
// return to 107 and 46, result queue empties.
// ----------------------------------------------------------------------------
// proxy_v1_header_parser_unit
// Detects and parses a PROXY v1 header line, streams the source host, reports
// family and source port, and passes the remaining bytes through.
// ----------------------------------------------------------------------------
module proxy_v1_header_parser_unit
	import pxhp_pkg::*;
#(
	parameter int HOST_LEN_LIMIT = HOST_LEN_LIMIT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            in_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            status,
	output logic                  data_valid,
	output logic [7:0]            data_byte,
	output logic                  host_valid,
	output logic [7:0]            host_byte,
	output logic [1:0]            family,
	output logic [15:0]           source_port,
	output logic                  last,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam logic [7:0] HOST_LIM_P = 8'(HOST_LEN_LIMIT);

	logic [7:0]  max_header_len_q;
	logic [5:0]  max_host_len_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;

	phase_t      phase_q, phase_n;
	logic [7:0]  held_byte_q, held_byte_n;
	logic [7:0]  line_count_q, line_count_n;
	logic [2:0]  token_index_q, token_index_n;
	logic [5:0]  token_pos_q, token_pos_n;
	logic [1:0]  family_q, family_n;
	logic [16:0] port_q, port_n;
	logic        cr_seen_q, cr_seen_n;

	parse_res_t  pres;
	res_t        res;

	res_t        q_q [2];
	logic        wr_q, rd_q, sub_q;
	logic [1:0]  count_q;

	logic        q_full, advance, pop, take;
	logic [7:0]  line_inc;
	logic [7:0]  host_lim;
	logic [20:0] port_mul;
	res_t        head;

	assign q_full   = (count_q == 2'd2);
	assign advance  = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;

	assign line_inc = (line_count_q < LINE_SAT) ? line_count_q + 8'd1 : line_count_q;
	assign host_lim = ({2'b00, max_host_len_q} > HOST_LIM_P) ? HOST_LIM_P
		: {2'b00, max_host_len_q};
	assign port_mul = {1'b0, port_q, 3'b000} + {3'b000, port_q, 1'b0}
		+ {13'd0, byte_s1 - CH_0};

	// next state
	always_comb begin
		phase_n       = phase_q;
		held_byte_n   = held_byte_q;
		line_count_n  = line_count_q;
		token_index_n = token_index_q;
		token_pos_n   = token_pos_q;
		family_n      = family_q;
		port_n        = port_q;
		cr_seen_n     = cr_seen_q;
		pres          = PR_PEND;
		case (phase_q)
			PH_DET0: begin
				held_byte_n  = byte_s1;
				line_count_n = 8'd1;
				phase_n      = PH_DET1;
			end
			PH_DET1: begin
				if (held_byte_q == CH_P && byte_s1 == CH_R) begin
					line_count_n  = 8'd2;
					token_index_n = TK_LEAD;
					token_pos_n   = 6'd2;
					phase_n       = PH_PARSE;
				end else begin
					phase_n = PH_NOHDR;
				end
			end
			PH_PARSE: begin
				line_count_n = line_inc;
				if (line_inc >= max_header_len_q) begin
					pres = PR_ERR;
				end else begin
					case (token_index_q)
						TK_LEAD: begin
							if (token_pos_q > 6'd5 || byte_s1 != lead_char(token_pos_q)) begin
								pres = PR_ERR;
							end else if (token_pos_q == 6'd5) begin
								token_index_n = TK_FAMILY;
								token_pos_n   = 6'd0;
							end else begin
								token_pos_n = token_pos_q + 6'd1;
							end
						end
						TK_FAMILY: begin
							if (token_pos_q < 6'd3) begin
								if (byte_s1 != fam_char(token_pos_q)) pres = PR_ERR;
								else token_pos_n = token_pos_q + 6'd1;
							end else if (token_pos_q == 6'd3) begin
								if (byte_s1 == CH_4) family_n = FAM_TCP4;
								else if (byte_s1 == CH_6) family_n = FAM_TCP6;
								else pres = PR_ERR;
								token_pos_n = 6'd4;
							end else if (byte_s1 != CH_SP) begin
								pres = PR_ERR;
							end else begin
								token_index_n = TK_SRC;
								token_pos_n   = 6'd0;
							end
						end
						TK_SRC: begin
							if (byte_s1 == CH_SP) begin
								if (token_pos_q == 6'd0) begin
									pres = PR_ERR;
								end else begin
									token_index_n = TK_DST;
									token_pos_n   = 6'd0;
								end
							end else if (byte_s1 == CH_CR || byte_s1 == CH_LF) begin
								pres = PR_ERR;
							end else if ({2'b00, token_pos_q} >= host_lim) begin
								pres = PR_ERR;
							end else begin
								token_pos_n = token_pos_q + 6'd1;
								pres        = PR_HOST;
							end
						end
						TK_DST: begin
							if (byte_s1 == CH_SP) begin
								if (token_pos_q == 6'd0) begin
									pres = PR_ERR;
								end else begin
									token_index_n = TK_SPORT;
									token_pos_n   = 6'd0;
								end
							end else if (byte_s1 == CH_CR || byte_s1 == CH_LF) begin
								pres = PR_ERR;
							end else begin
								token_pos_n = 6'd1;
							end
						end
						TK_SPORT: begin
							if (byte_s1 == CH_SP) begin
								if (token_pos_q == 6'd0 || port_q == 17'd0 || port_q > PORT_MAX) begin
									pres = PR_ERR;
								end else begin
									token_index_n = TK_TAIL;
									token_pos_n   = 6'd0;
								end
							end else if (byte_s1 < CH_0 || byte_s1 > CH_9) begin
								pres = PR_ERR;
							end else begin
								port_n      = (port_mul > 21'(PORT_MAX)) ? PORT_SAT : port_mul[16:0];
								token_pos_n = 6'd1;
							end
						end
						TK_TAIL: begin
							if (cr_seen_q) begin
								if (byte_s1 != CH_LF) pres = PR_ERR;
								else pres = PR_ACC;
							end else if (byte_s1 == CH_CR) begin
								if (token_pos_q == 6'd0) pres = PR_ERR;
								else cr_seen_n = 1'b1;
							end else if (byte_s1 == CH_SP || byte_s1 == CH_LF) begin
								pres = PR_ERR;
							end else begin
								token_pos_n = 6'd1;
							end
						end
						default: pres = PR_ERR;
					endcase
				end
				if (pres == PR_ERR) phase_n = PH_ERR;
				else if (pres == PR_ACC) phase_n = PH_ACC;
			end
			PH_ACC:   phase_n = PH_ACC;
			PH_NOHDR: phase_n = PH_NOHDR;
			default:  phase_n = PH_ERR;
		endcase
	end

	// result word
	always_comb begin
		res             = '0;
		res.status      = ST_PENDING;
		res.family      = family_n;
		res.source_port = (phase_n == PH_ACC) ? port_n[15:0] : 16'd0;
		case (phase_q)
			PH_DET0: res.status = ST_PENDING;
			PH_DET1: begin
				if (phase_n == PH_NOHDR) begin
					res.status     = ST_NOHDR;
					res.data_valid = 1'b1;
					res.data_byte  = held_byte_q;
					res.pair       = 1'b1;
					res.data_byte2 = byte_s1;
				end
			end
			PH_PARSE: begin
				case (pres)
					PR_ERR:  res.status = ST_ERROR;
					PR_ACC:  res.status = ST_ACCEPTED;
					PR_HOST: begin
						res.host_valid = 1'b1;
						res.host_byte  = byte_s1;
					end
					default: res.status = ST_PENDING;
				endcase
			end
			PH_ACC: begin
				res.status     = ST_DATA;
				res.data_valid = 1'b1;
				res.data_byte  = byte_s1;
			end
			PH_NOHDR: begin
				res.status     = ST_NOHDR;
				res.data_valid = 1'b1;
				res.data_byte  = byte_s1;
			end
			default: res.status = ST_ERROR;
		endcase
	end

	assign head        = q_q[rd_q];
	assign out_valid   = (count_q != 2'd0);
	assign last        = !head.pair || sub_q;
	assign status      = head.status;
	assign data_valid  = head.data_valid;
	assign data_byte   = sub_q ? head.data_byte2 : head.data_byte;
	assign host_valid  = head.host_valid;
	assign host_byte   = head.host_byte;
	assign family      = head.family;
	assign source_port = head.source_port;
	assign take        = out_valid && !out_stall;
	assign pop         = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_header_len_q <= MAX_HEADER_LEN_RST;
			max_host_len_q   <= MAX_HOST_LEN_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MAX_HEADER_LEN) max_header_len_q <= cfg_wdata;
			else if (cfg_index == CFG_MAX_HOST_LEN) max_host_len_q <= cfg_wdata[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) byte_s1 <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_DET0;
			held_byte_q   <= 8'd0;
			line_count_q  <= 8'd0;
			token_index_q <= 3'd0;
			token_pos_q   <= 6'd0;
			family_q      <= FAM_UNKNOWN;
			port_q        <= 17'd0;
			cr_seen_q     <= 1'b0;
		end else if (advance) begin
			phase_q       <= phase_n;
			held_byte_q   <= held_byte_n;
			line_count_q  <= line_count_n;
			token_index_q <= token_index_n;
			token_pos_q   <= token_pos_n;
			family_q      <= family_n;
			port_q        <= port_n;
			cr_seen_q     <= cr_seen_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) q_q[wr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			sub_q   <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (advance) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (take) sub_q <= !last;
			case ({advance, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== tb/sv/proxy_v1_header_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proxy_v1_header_parser_unit_tb
// Streams one connection into the header parser: a PROXY v1 line, mostly well
// formed with random hosts, ports and families, sometimes corrupted or replaced
// by a stream without header, then random payload. A behavioral copy of the
// parser predicts every result word; the monitor checks them field by field.
// Both handshakes idle at random, and the limit registers change between bursts.
// ----------------------------------------------------------------------------
module proxy_v1_header_parser_unit_tb;
	import pxhp_pkg::*;

	localparam int                   STALL_LIMIT = 1000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
	localparam logic [47:0]          LEAD_TEXT   = "PROXY ";
	localparam logic [23:0]          FAM_TEXT    = "TCP";

	typedef struct packed {
		status_t     st;
		logic        dv;
		logic [7:0]  db;
		logic        hv;
		logic [7:0]  hb;
		family_t     fam;
		logic [15:0] port;
		logic        lst;
	} parse_out_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [7:0]            in_byte     = 8'h00;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [2:0]            status;
	logic                  data_valid;
	logic [7:0]            data_byte;
	logic                  host_valid;
	logic [7:0]            host_byte;
	logic [1:0]            family;
	logic [15:0]           source_port;
	logic                  last;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

	logic [7:0] tx_bytes[$];
	logic [7:0] hdr_bytes[$];
	parse_out_t parser_results[$];
	int         mismatch_cnt = 0;
	int         send_gap     = 0;
	int         hold_cnt     = 0;
	int         idle_cycles  = 0;
	logic       tx_calm      = 1'b0;
	logic       rx_calm      = 1'b0;

	// parser image
	logic [7:0] hdr_len_lim  = MAX_HEADER_LEN_RST;
	logic [5:0] host_len_reg = MAX_HOST_LEN_RST;
	phase_t     ph           = PH_DET0;
	logic [7:0] held         = 8'h00;
	int         line_cnt     = 0;
	token_t     tok          = TK_LEAD;
	int         tok_pos      = 0;
	family_t    fam_seen     = FAM_UNKNOWN;
	int         port_acc     = 0;
	logic       cr_flag      = 1'b0;

	proxy_v1_header_parser_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.data_valid  (data_valid),
		.data_byte   (data_byte),
		.host_valid  (host_valid),
		.host_byte   (host_byte),
		.family      (family),
		.source_port (source_port),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic void emit(status_t st, logic dv, logic [7:0] db, logic hv,
			logic [7:0] hb, logic lst);
		parse_out_t w;
		w.st   = st;
		w.dv   = dv;
		w.db   = dv ? db : 8'h00;
		w.hv   = hv;
		w.hb   = hv ? hb : 8'h00;
		w.fam  = fam_seen;
		w.port = (ph == PH_ACC) ? port_acc[15:0] : 16'h0000;
		w.lst  = lst;
		parser_results.push_back(w);
	endfunction

	function automatic parse_res_t scan_header_byte(logic [7:0] b);
		int lim;
		lim = host_len_reg;
		if (lim > HOST_LEN_LIMIT_DEF) lim = HOST_LEN_LIMIT_DEF;
		if (line_cnt < LINE_SAT) line_cnt++;
		if (line_cnt >= hdr_len_lim) return PR_ERR;
		case (tok)
			TK_LEAD: begin
				if (tok_pos > 5 || b != LEAD_TEXT[47 - 8 * tok_pos -: 8]) return PR_ERR;
				tok_pos++;
				if (tok_pos == 6) begin
					tok     = TK_FAMILY;
					tok_pos = 0;
				end
				return PR_PEND;
			end
			TK_FAMILY: begin
				if (tok_pos < 3) begin
					if (b != FAM_TEXT[23 - 8 * tok_pos -: 8]) return PR_ERR;
					tok_pos++;
					return PR_PEND;
				end
				if (tok_pos == 3) begin
					if (b == CH_4) fam_seen = FAM_TCP4;
					else if (b == CH_6) fam_seen = FAM_TCP6;
					else return PR_ERR;
					tok_pos = 4;
					return PR_PEND;
				end
				if (b != CH_SP) return PR_ERR;
				tok     = TK_SRC;
				tok_pos = 0;
				return PR_PEND;
			end
			TK_SRC: begin
				if (b == CH_SP) begin
					if (tok_pos == 0) return PR_ERR;
					tok     = TK_DST;
					tok_pos = 0;
					return PR_PEND;
				end
				if (b == CH_CR || b == CH_LF) return PR_ERR;
				if (tok_pos >= lim) return PR_ERR;
				tok_pos++;
				return PR_HOST;
			end
			TK_DST: begin
				if (b == CH_SP) begin
					if (tok_pos == 0) return PR_ERR;
					tok     = TK_SPORT;
					tok_pos = 0;
					return PR_PEND;
				end
				if (b == CH_CR || b == CH_LF) return PR_ERR;
				tok_pos = 1;
				return PR_PEND;
			end
			TK_SPORT: begin
				if (b == CH_SP) begin
					if (tok_pos == 0) return PR_ERR;
					if (port_acc == 0 || port_acc > PORT_MAX) return PR_ERR;
					tok     = TK_TAIL;
					tok_pos = 0;
					return PR_PEND;
				end
				if (b < CH_0 || b > CH_9) return PR_ERR;
				port_acc = port_acc * 10 + (b - CH_0);
				if (port_acc > PORT_MAX) port_acc = PORT_SAT;
				tok_pos = 1;
				return PR_PEND;
			end
			TK_TAIL: begin
				if (cr_flag) begin
					if (b != CH_LF) return PR_ERR;
					return PR_ACC;
				end
				if (b == CH_CR) begin
					if (tok_pos == 0) return PR_ERR;
					cr_flag = 1'b1;
					return PR_PEND;
				end
				if (b == CH_SP || b == CH_LF) return PR_ERR;
				tok_pos = 1;
				return PR_PEND;
			end
			default: return PR_ERR;
		endcase
	endfunction

	function automatic void advance_parser(logic [7:0] b);
		parse_res_t r;
		case (ph)
			PH_DET0: begin
				held     = b;
				line_cnt = 1;
				ph       = PH_DET1;
				emit(ST_PENDING, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
			end
			PH_DET1: begin
				if (held == CH_P && b == CH_R) begin
					line_cnt = 2;
					tok      = TK_LEAD;
					tok_pos  = 2;
					ph       = PH_PARSE;
					emit(ST_PENDING, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
				end else begin
					ph = PH_NOHDR;
					emit(ST_NOHDR, 1'b1, held, 1'b0, 8'h00, 1'b0);
					emit(ST_NOHDR, 1'b1, b, 1'b0, 8'h00, 1'b1);
				end
			end
			PH_PARSE: begin
				r = scan_header_byte(b);
				case (r)
					PR_ERR: begin
						ph = PH_ERR;
						emit(ST_ERROR, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
					end
					PR_ACC: begin
						ph = PH_ACC;
						emit(ST_ACCEPTED, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
					end
					PR_HOST: emit(ST_PENDING, 1'b0, 8'h00, 1'b1, b, 1'b1);
					default: emit(ST_PENDING, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
				endcase
			end
			PH_ACC:   emit(ST_DATA, 1'b1, b, 1'b0, 8'h00, 1'b1);
			PH_NOHDR: emit(ST_NOHDR, 1'b1, b, 1'b0, 8'h00, 1'b1);
			default: begin
				ph = PH_ERR;
				emit(ST_ERROR, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
			mismatch_cnt++;
		end
	endfunction

	// driver: advance one word per free slot, hold the word while stalled
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) advance_parser(in_byte);
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (tx_bytes.size() != 0) begin
				in_valid <= 1'b1;
				in_byte  <= tx_bytes.pop_front();
				if ($urandom_range(0, 49) == 0) tx_calm <= !tx_calm;
				send_gap <= tx_calm ? 0 : $urandom_range(0, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		parse_out_t w;
		int hold;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_cnt  <= 0;
		end else begin
			hold = hold_cnt;
			if (out_valid && !out_stall) begin
				if (parser_results.size() == 0) begin
					$display("%0t ns: result with none expected, status %0d data 0x%0h",
						$time, status, data_byte);
					mismatch_cnt++;
				end else begin
					w = parser_results.pop_front();
					check_field("status", 16'(w.st), 16'(status));
					check_field("data_valid", 16'(w.dv), 16'(data_valid));
					check_field("data_byte", 16'(w.db), 16'(data_byte));
					check_field("host_valid", 16'(w.hv), 16'(host_valid));
					check_field("host_byte", 16'(w.hb), 16'(host_byte));
					check_field("family", 16'(w.fam), 16'(family));
					check_field("source_port", w.port, source_port);
					check_field("last", 16'(w.lst), 16'(last));
				end
				if ($urandom_range(0, 49) == 0) rx_calm <= !rx_calm;
				hold = rx_calm ? 0 : $urandom_range(0, 3);
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				hold_cnt  <= hold - 1;
			end else begin
				out_stall <= 1'b0;
				hold_cnt  <= 0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("proxy_v1_header_parser_unit: mismatch");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_HEADER_LEN) hdr_len_lim = val;
		else if (idx == CFG_MAX_HOST_LEN) host_len_reg = val[5:0];
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (tx_bytes.size() != 0 || in_valid || parser_results.size() != 0);
	endtask

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) hdr_bytes.push_back(s[i]);
	endfunction

	function automatic logic [7:0] token_char();
		if ($urandom_range(0, 99) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	function automatic logic [7:0] pick_line_limit(int need);
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(need < 255 ? need + 1 : 255, 255));
		case ($urandom_range(0, 3))
			0:       return 8'd16;
			1:       return 8'd255;
			2:       return 8'd0;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_host_limit(int need);
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(need < 1 ? 1 : (need > 63 ? 63 : need), 63));
		case ($urandom_range(0, 3))
			0:       return 8'd0;
			1:       return 8'd1;
			2:       return 8'd63;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin : stim
		int         host_n;
		int         n;
		int         v;
		int         split;
		int         pos;
		int         payload_n;
		logic [7:0] b;

		// build the header line for this connection
		host_n = 0;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 2))
				0: begin
					hdr_bytes.push_back(CH_P);
					b = 8'($urandom_range(0, 255));
					hdr_bytes.push_back(b == CH_R ? ~b : b);
				end
				1: begin
					b = 8'($urandom_range(0, 255));
					hdr_bytes.push_back(b == CH_P ? ~b : b);
					hdr_bytes.push_back(CH_R);
				end
				default: begin
					hdr_bytes.push_back(8'($urandom_range(0, 255)));
					hdr_bytes.push_back(8'($urandom_range(0, 255)));
				end
			endcase
		end else begin
			push_text("PROXY TCP");
			if ($urandom_range(0, 9) == 0) hdr_bytes.push_back(8'($urandom_range(0, 255)));
			else hdr_bytes.push_back($urandom_range(0, 1) ? CH_4 : CH_6);
			hdr_bytes.push_back(CH_SP);
			case ($urandom_range(0, 19))
				0:       host_n = 0;
				1, 2:    host_n = $urandom_range(40, 66);
				default: host_n = $urandom_range(1, 16);
			endcase
			for (int i = 0; i < host_n; i++) hdr_bytes.push_back(token_char());
			hdr_bytes.push_back(CH_SP);
			n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
			for (int i = 0; i < n; i++) hdr_bytes.push_back(token_char());
			hdr_bytes.push_back(CH_SP);
			case ($urandom_range(0, 9))
				0:       v = 0;
				1:       v = 65535;
				2:       v = 65536;
				3:       v = 1;
				4:       v = $urandom_range(65537, 9999999);
				default: v = $urandom_range(1, 65535);
			endcase
			if ($urandom_range(0, 19) != 0) begin
				if ($urandom_range(0, 4) == 0) begin
					n = $urandom_range(1, 3);
					for (int i = 0; i < n; i++) hdr_bytes.push_back(CH_0);
				end
				push_text($sformatf("%0d", v));
			end
			hdr_bytes.push_back(CH_SP);
			n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
			for (int i = 0; i < n; i++) hdr_bytes.push_back(token_char());
			hdr_bytes.push_back(CH_CR);
			if ($urandom_range(0, 19) == 0) begin
				b = 8'($urandom_range(0, 255));
				hdr_bytes.push_back(b == CH_LF ? CH_SP : b);
			end else begin
				hdr_bytes.push_back(CH_LF);
			end
			if ($urandom_range(0, 3) == 0) begin
				pos = $urandom_range(2, hdr_bytes.size() - 1);
				case ($urandom_range(0, 4))
					0:       hdr_bytes[pos] = CH_SP;
					1:       hdr_bytes[pos] = CH_CR;
					2:       hdr_bytes[pos] = CH_LF;
					3:       hdr_bytes[pos] = 8'($urandom_range(0, 255));
					default: hdr_bytes.delete(pos);
				endcase
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(CFG_MAX_HEADER_LEN, pick_line_limit(hdr_bytes.size()));
		write_reg(CFG_MAX_HOST_LEN, pick_host_limit(host_n));

		// header in two bursts, limits rewritten in between
		split = $urandom_range(1, hdr_bytes.size() - 1);
		@(negedge clk);
		for (int i = 0; i < split; i++) tx_bytes.push_back(hdr_bytes[i]);
		wait_drained();
		write_reg(CFG_MAX_HEADER_LEN, pick_line_limit(hdr_bytes.size()));
		write_reg(CFG_MAX_HOST_LEN, pick_host_limit(host_n));
		if ($urandom_range(0, 1)) write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
		@(negedge clk);
		for (int i = split; i < hdr_bytes.size(); i++) tx_bytes.push_back(hdr_bytes[i]);
		wait_drained();

		// payload bursts across the register extremes
		payload_n = (1200 - hdr_bytes.size()) / 4;
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: begin
					write_reg(CFG_MAX_HEADER_LEN, 8'd16);
					write_reg(CFG_MAX_HOST_LEN, 8'd1);
				end
				1: begin
					write_reg(CFG_MAX_HEADER_LEN, 8'd255);
					write_reg(CFG_MAX_HOST_LEN, 8'd63);
				end
				2: begin
					write_reg(CFG_MAX_HEADER_LEN, 8'd0);
					write_reg(CFG_MAX_HOST_LEN, 8'd0);
				end
				default: begin
					write_reg(CFG_MAX_HEADER_LEN, 8'($urandom_range(0, 255)));
					write_reg(CFG_MAX_HOST_LEN, 8'($urandom_range(0, 255)));
					write_reg(CFG_SPARE - 2'd1, 8'($urandom_range(0, 255)));
				end
			endcase
			@(negedge clk);
			if (k == 0) begin
				tx_bytes.push_back(8'h00);
				tx_bytes.push_back(8'hFF);
			end
			for (int i = 0; i < payload_n; i++) tx_bytes.push_back(8'($urandom_range(0, 255)));
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("proxy_v1_header_parser_unit: match");
		end else begin
			$display("proxy_v1_header_parser_unit: mismatch");
		end
		$finish;
	end

endmodule
